>>> rtl/assert_macros.svh
// assertion macros for the pedal speed regulator rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PSR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");
`define PSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define PSR_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PSR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/psr_pkg.sv
// shared types and constants for the pedal speed regulator
// no dependencies; imported by every module of the block
package psr_pkg;

  localparam int unsigned LevelW = 14;
  localparam int unsigned SpeedW = 16;
  localparam int unsigned ZoneW  = 15;
  localparam int unsigned GainW  = 12;
  localparam int unsigned CfgW   = 15;
  localparam int unsigned IdxW   = 3;

  typedef enum logic [IdxW-1:0] {
    REG_AUTO_BRAKE  = 3'd0,
    REG_ACCEL_CEIL  = 3'd1,
    REG_ACCEL_FLOOR = 3'd2,
    REG_BRAKE_CEIL  = 3'd3,
    REG_ZONE_SPEED  = 3'd4,
    REG_DEADBAND    = 3'd5,
    REG_ACCEL_GAIN  = 3'd6,
    REG_BRAKE_GAIN  = 3'd7
  } psr_reg_e;

  localparam logic [LevelW-1:0]       AutoBrakeRst  = 14'd4608;
  localparam logic [LevelW-1:0]       AccelCeilRst  = 14'd7680;
  localparam logic [LevelW-1:0]       AccelFloorRst = 14'd6400;
  localparam logic [LevelW-1:0]       BrakeCeilRst  = 14'd4608;
  localparam logic [ZoneW-1:0]        ZoneSpeedRst  = 15'd356;
  localparam logic [ZoneW-1:0]        DeadbandRst   = 15'd256;
  localparam logic signed [GainW-1:0] AccelGainRst  = 12'sd26;
  localparam logic signed [GainW-1:0] BrakeGainRst  = -12'sd26;

  typedef struct packed {
    logic [LevelW-1:0]       auto_brake;
    logic [LevelW-1:0]       accel_ceil;
    logic [LevelW-1:0]       accel_floor;
    logic [LevelW-1:0]       brake_ceil;
    logic [ZoneW-1:0]        zone_speed;
    logic [ZoneW-1:0]        deadband;
    logic signed [GainW-1:0] accel_gain;
    logic signed [GainW-1:0] brake_gain;
  } psr_cfg_t;

endpackage

>>> rtl/pedal_speed_regulator.sv
// Pedal speed regulator: each transaction carries a target and a measured speed
// (signed q8.8) and returns one accelerator and one brake level (unsigned q6.8). An
// accepted transaction is held in the input register, then a single
// combinational pass updates the two stored levels, which also serve as the
// result register. The input register and the level registers make up the
// two register stages from input port to result port;
// a new transaction is taken every cycle while the result side keeps up.
// Configuration writes take effect on the next edge and belong in idle periods.
// depends on psr_pkg, psr_cfg_regs, psr_update and assert_macros.svh
module pedal_speed_regulator (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [psr_pkg::IdxW-1:0]           cfg_index_i,
  input  logic [psr_pkg::CfgW-1:0]           cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [psr_pkg::SpeedW-1:0]  target_speed_i,
  input  logic signed [psr_pkg::SpeedW-1:0]  measured_speed_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [psr_pkg::LevelW-1:0]         accel_level_o,
  output logic [psr_pkg::LevelW-1:0]         brake_level_o
);
  import psr_pkg::*;
  `include "assert_macros.svh"

  psr_cfg_t                 cfg;
  logic                     in_valid_q;
  logic signed [SpeedW-1:0] target_q;
  logic signed [SpeedW-1:0] measured_q;
  logic                     out_valid_q;
  logic [LevelW-1:0]        accel_q, accel_d;
  logic [LevelW-1:0]        brake_q, brake_d;
  logic                     advance;
  logic                     fire;

  psr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  psr_update u_update (
    .cfg_i      (cfg),
    .target_i   (target_q),
    .measured_i (measured_q),
    .accel_i    (accel_q),
    .brake_i    (brake_q),
    .accel_o    (accel_d),
    .brake_o    (brake_d)
  );

  assign advance    = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      accel_q     <= '0;
      brake_q     <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      if (fire) begin
        accel_q <= accel_d;
        brake_q <= brake_d;
      end
    end
  end

  // input payload register
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      target_q   <= target_speed_i;
      measured_q <= measured_speed_i;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign accel_level_o = accel_q;
  assign brake_level_o = brake_q;

  `PSR_ASSERT_NEXT(a_fire_gives_result, clk_i, rst_ni, fire, out_valid_q)
  `PSR_ASSERT_NEXT(a_held_item_kept, clk_i, rst_ni, in_valid_q && !advance, in_valid_q)
  `PSR_ASSERT_NEXT(a_drain_clears, clk_i, rst_ni, out_valid_q && out_ready_i && !in_valid_q, !out_valid_q)
  `PSR_ASSERT_NEXT(a_levels_hold_on_stall, clk_i, rst_ni, !fire, $stable(accel_q) && $stable(brake_q))

endmodule

>>> rtl/psr_cfg_regs.sv
// configuration register bank of the pedal speed regulator
// depends on psr_pkg
module psr_cfg_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [psr_pkg::IdxW-1:0]  cfg_index_i,
  input  logic [psr_pkg::CfgW-1:0]  cfg_data_i,
  output psr_pkg::psr_cfg_t         cfg_o
);
  import psr_pkg::*;

  psr_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.auto_brake  <= AutoBrakeRst;
      cfg_q.accel_ceil  <= AccelCeilRst;
      cfg_q.accel_floor <= AccelFloorRst;
      cfg_q.brake_ceil  <= BrakeCeilRst;
      cfg_q.zone_speed  <= ZoneSpeedRst;
      cfg_q.deadband    <= DeadbandRst;
      cfg_q.accel_gain  <= AccelGainRst;
      cfg_q.brake_gain  <= BrakeGainRst;
    end else if (cfg_we_i) begin
      case (psr_reg_e'(cfg_index_i))
        REG_AUTO_BRAKE:  cfg_q.auto_brake  <= cfg_data_i[LevelW-1:0];
        REG_ACCEL_CEIL:  cfg_q.accel_ceil  <= cfg_data_i[LevelW-1:0];
        REG_ACCEL_FLOOR: cfg_q.accel_floor <= cfg_data_i[LevelW-1:0];
        REG_BRAKE_CEIL:  cfg_q.brake_ceil  <= cfg_data_i[LevelW-1:0];
        REG_ZONE_SPEED:  cfg_q.zone_speed  <= cfg_data_i[ZoneW-1:0];
        REG_DEADBAND:    cfg_q.deadband    <= cfg_data_i[ZoneW-1:0];
        REG_ACCEL_GAIN:  cfg_q.accel_gain  <= $signed(cfg_data_i[GainW-1:0]);
        REG_BRAKE_GAIN:  cfg_q.brake_gain  <= $signed(cfg_data_i[GainW-1:0]);
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/psr_update.sv
// combinational level update: error, deadband and zone decode, gain step and clamps
// depends on psr_pkg
module psr_update (
  input  psr_pkg::psr_cfg_t                cfg_i,
  input  logic signed [psr_pkg::SpeedW-1:0] target_i,
  input  logic signed [psr_pkg::SpeedW-1:0] measured_i,
  input  logic [psr_pkg::LevelW-1:0]        accel_i,
  input  logic [psr_pkg::LevelW-1:0]        brake_i,
  output logic [psr_pkg::LevelW-1:0]        accel_o,
  output logic [psr_pkg::LevelW-1:0]        brake_o
);
  import psr_pkg::*;

  // gain (q4.8) times error (q9.8), rounded to nearest q8.8, ties upward
  function automatic logic signed [20:0] scaled_step(logic signed [GainW-1:0] gain,
                                                     logic signed [SpeedW:0]  err);
    logic signed [28:0] prod;
    logic signed [29:0] sum;
    prod = 29'(gain) * 29'(err);
    sum  = 30'(prod) + 30'sd128;
    return sum[28:8];
  endfunction

  logic signed [SpeedW:0] err;
  logic [SpeedW:0]        mag;
  logic                   in_deadband;
  logic                   in_zone;
  logic                   target_zero;
  logic signed [21:0]     accel_sum;
  logic signed [21:0]     brake_sum;
  logic [LevelW-1:0]      accel_clamped;
  logic [LevelW-1:0]      brake_clamped;

  always_comb begin
    err         = {target_i[SpeedW-1], target_i} - {measured_i[SpeedW-1], measured_i};
    mag         = err[SpeedW] ? (SpeedW+1)'(-err) : err;
    in_deadband = mag < {2'b00, cfg_i.deadband};
    target_zero = target_i == '0;
    in_zone     = !target_i[SpeedW-1] && !target_zero &&
                  ({target_i[SpeedW-1], target_i} <= $signed({2'b00, cfg_i.zone_speed}));

    accel_sum = $signed({8'b0, accel_i}) + 22'(scaled_step(cfg_i.accel_gain, err));
    brake_sum = $signed({8'b0, brake_i}) + 22'(scaled_step(cfg_i.brake_gain, err));

    // ceiling tested before floor
    if (accel_sum >= $signed({8'b0, cfg_i.accel_ceil})) begin
      accel_clamped = cfg_i.accel_ceil;
    end else if (accel_sum <= $signed({8'b0, cfg_i.accel_floor})) begin
      accel_clamped = cfg_i.accel_floor;
    end else begin
      accel_clamped = accel_sum[LevelW-1:0];
    end

    if (brake_sum <= 22'sd0) begin
      brake_clamped = '0;
    end else if (brake_sum >= $signed({8'b0, cfg_i.brake_ceil})) begin
      brake_clamped = cfg_i.brake_ceil;
    end else begin
      brake_clamped = brake_sum[LevelW-1:0];
    end

    if (in_deadband) begin
      accel_o = accel_i;
      brake_o = target_zero ? cfg_i.auto_brake : brake_i;
    end else if (in_zone || !(err > 0)) begin
      accel_o = '0;
      brake_o = brake_clamped;
    end else begin
      accel_o = accel_clamped;
      brake_o = '0;
    end
  end

endmodule
